// File: rtl/assert_macros.svh
// assert_macros.svh: concurrent assertion helpers used by bottom_up_merge_sorter.sv
// depends on nothing; each user passes its own clock and active-low reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/bums_pkg.sv
// bums_pkg: request types and sequencer states of the merge sorter
// no dependencies
`default_nettype none

package bums_pkg;

    // width of the value fields on both channels
    localparam int IO_W = 32;

    typedef struct packed {
        logic signed [IO_W-1:0] value;
        logic                   last;
    } sort_in_t;

    typedef struct packed {
        logic signed [IO_W-1:0] sorted_value;
        logic                   final_res;
        logic                   overflow;
    } sort_out_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_PASS_CHK,
        ST_PASS_END,
        ST_MRG_RDL,
        ST_MRG_RDR,
        ST_MRG_GETR,
        ST_MRG_STEP,
        ST_MRG_REFILL,
        ST_MRG_COPY,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_HOLD
    } sort_state_t;

endpackage

`default_nettype wire

// File: rtl/bums_ram.sv
// bums_ram: generic simple dual-port ram, one write and one registered read
// no dependencies
`default_nettype none

module bums_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/bottom_up_merge_sorter.sv
// bottom_up_merge_sorter: batch sorter for signed values, top level; uses bums_pkg, bums_ram
// and assert_macros.svh. Values come in one request per cycle on the item channel, up to
// MAX_LEN per batch (extra ones are dropped and flag overflow on every result), and the
// request marked last starts a stable ascending bottom-up merge sort held in two rams: the
// sort store and a merge buffer. Each pass merges runs into the buffer and copies them back;
// because the sort store has a single read port, values are read one at a time, over
// ceil(log2 n) passes of doubling run width. Results then leave one at a time when the
// result side is ready, each read from the sort store and registered first; no new item is
// taken until the last result of the batch has been taken. No clearing pass is needed
// after reset.
`default_nettype none

`include "assert_macros.svh"

module bottom_up_merge_sorter
    import bums_pkg::*;
#(
    parameter int MAX_LEN    = 64,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      item_valid,
    output logic           item_ready,
    input  wire sort_in_t  item,
    output logic           result_valid,
    input  wire logic      result_ready,
    output sort_out_t      result
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int RW = CW + 1;
    localparam int EW = RW + 1;
    localparam int SW = (DATA_WIDTH < IO_W) ? DATA_WIDTH : IO_W;

    // control state
    sort_state_t    state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           dropped_reg, dropped_next;
    logic [RW-1:0]  rw_reg, rw_next;
    logic [CW-1:0]  lo_reg, lo_next;
    logic [AW-1:0]  tm_reg, tm_next;
    logic           tm_vld_reg, tm_vld_next;
    logic           tail_reg, tail_next;
    logic [AW-1:0]  m_lo_reg, m_lo_next;
    logic [AW-1:0]  mid_reg, mid_next;
    logic [AW-1:0]  hi_reg, hi_next;
    logic [CW-1:0]  l_ptr_reg, l_ptr_next;
    logic [CW-1:0]  r_ptr_reg, r_ptr_next;
    logic [CW-1:0]  k_reg, k_next;
    logic           take_r_reg, take_r_next;
    logic [CW-1:0]  cp_i_reg, cp_i_next;
    logic           cp_wv_reg, cp_wv_next;
    logic [AW-1:0]  cp_waddr_reg, cp_waddr_next;
    logic [AW-1:0]  emit_k_reg, emit_k_next;
    logic           out_valid_reg, out_valid_next;

    // payload registers
    logic signed [SW-1:0] head_l_reg, head_l_next;
    logic signed [SW-1:0] head_r_reg, head_r_next;
    sort_out_t            out_reg, out_next;

    // ram ports
    logic          ss_we;
    logic [AW-1:0] ss_waddr;
    logic [SW-1:0] ss_wdata;
    logic [AW-1:0] ss_raddr;
    logic [SW-1:0] ss_rdata;
    logic          buf_we;
    logic [AW-1:0] buf_waddr;
    logic [SW-1:0] buf_wdata;
    logic [AW-1:0] buf_raddr;
    logic [SW-1:0] buf_rdata;

    // shared decode
    logic          accept;
    logic          in_room;
    logic [CW-1:0] n_after;
    logic [EW-1:0] run_end;
    logic          full_run;
    logic [EW-1:0] full_mid;
    logic [CW:0]   tail_sum;
    logic [AW-1:0] tm_eff;
    logic          tail_has;
    logic          tail_merge;
    logic          tail_skip;
    logic          l_ok;
    logic          r_ok;
    logic          take_r;
    logic          cp_issue;
    logic          emit_final;

    bums_ram #(.WIDTH(SW), .DEPTH(MAX_LEN)) u_sort_store (
        .clk   (clk),
        .we    (ss_we),
        .waddr (ss_waddr),
        .wdata (ss_wdata),
        .raddr (ss_raddr),
        .rdata (ss_rdata)
    );

    bums_ram #(.WIDTH(SW), .DEPTH(MAX_LEN)) u_merge_buf (
        .clk   (clk),
        .we    (buf_we),
        .waddr (buf_waddr),
        .wdata (buf_wdata),
        .raddr (buf_raddr),
        .rdata (buf_rdata)
    );

    // load side decode
    assign accept  = item_valid && item_ready;
    assign in_room = count_reg < CW'(MAX_LEN);
    assign n_after = count_reg + CW'(in_room);

    // pass control: full run or tail at lo
    assign run_end    = EW'(lo_reg) + EW'(rw_reg);
    assign full_run   = run_end <= EW'(count_reg);
    assign full_mid   = EW'(lo_reg) + EW'(rw_reg >> 1) - EW'(1);
    assign tail_sum   = (CW+1)'(count_reg) - (CW+1)'(1) + (CW+1)'(lo_reg);
    assign tm_eff     = tm_vld_reg ? tm_reg : AW'(tail_sum >> 1);
    assign tail_has   = lo_reg < count_reg;
    assign tail_merge = CW'(tm_eff) >= lo_reg;
    assign tail_skip  = lo_reg >= (count_reg - CW'(1));

    // merge step decode, earlier value wins on a tie
    assign l_ok   = l_ptr_reg <= CW'(mid_reg);
    assign r_ok   = r_ptr_reg <= CW'(hi_reg);
    assign take_r = r_ok && (!l_ok || (head_r_reg < head_l_reg));

    // copy-back and emit decode
    assign cp_issue   = cp_i_reg < k_reg;
    assign emit_final = (CW'(emit_k_reg) + CW'(1)) == count_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (accept && item.last)
                begin
                    state_next = (n_after < CW'(2)) ? ST_EMIT_RD : ST_PASS_CHK;
                end
            end
            ST_PASS_CHK:
            begin
                if (full_run)
                begin
                    state_next = ST_MRG_RDL;
                end
                else if (tail_has && tail_merge && !tail_skip)
                begin
                    state_next = ST_MRG_RDL;
                end
                else
                begin
                    state_next = ST_PASS_END;
                end
            end
            ST_PASS_END:
            begin
                state_next = (rw_reg >= RW'(count_reg)) ? ST_EMIT_RD : ST_PASS_CHK;
            end
            ST_MRG_RDL:    state_next = ST_MRG_RDR;
            ST_MRG_RDR:    state_next = ST_MRG_GETR;
            ST_MRG_GETR:   state_next = ST_MRG_STEP;
            ST_MRG_STEP:
            begin
                state_next = (l_ok || r_ok) ? ST_MRG_REFILL : ST_MRG_COPY;
            end
            ST_MRG_REFILL: state_next = ST_MRG_STEP;
            ST_MRG_COPY:
            begin
                if (!cp_issue && !cp_wv_reg)
                begin
                    state_next = tail_reg ? ST_PASS_END : ST_PASS_CHK;
                end
            end
            ST_EMIT_RD:    state_next = ST_EMIT_LD;
            ST_EMIT_LD:    state_next = ST_EMIT_HOLD;
            ST_EMIT_HOLD:
            begin
                if (result_ready)
                begin
                    state_next = emit_final ? ST_LOAD : ST_EMIT_RD;
                end
            end
            default:       state_next = ST_LOAD;
        endcase
    end

    // outputs, ram controls and datapath next values
    always_comb
    begin
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        rw_next        = rw_reg;
        lo_next        = lo_reg;
        tm_next        = tm_reg;
        tm_vld_next    = tm_vld_reg;
        tail_next      = tail_reg;
        m_lo_next      = m_lo_reg;
        mid_next       = mid_reg;
        hi_next        = hi_reg;
        l_ptr_next     = l_ptr_reg;
        r_ptr_next     = r_ptr_reg;
        k_next         = k_reg;
        take_r_next    = take_r_reg;
        cp_i_next      = cp_i_reg;
        cp_wv_next     = 1'b0;
        cp_waddr_next  = cp_waddr_reg;
        emit_k_next    = emit_k_reg;
        out_valid_next = out_valid_reg;
        head_l_next    = head_l_reg;
        head_r_next    = head_r_reg;
        out_next       = out_reg;

        item_ready = 1'b0;
        ss_we      = 1'b0;
        ss_waddr   = cp_waddr_reg;
        ss_wdata   = buf_rdata;
        ss_raddr   = emit_k_reg;
        buf_we     = 1'b0;
        buf_waddr  = AW'(k_reg);
        buf_wdata  = take_r ? head_r_reg : head_l_reg;
        buf_raddr  = AW'(cp_i_reg);

        case (state_reg)
            ST_LOAD:
            begin
                item_ready = 1'b1;
                if (accept)
                begin
                    if (in_room)
                    begin
                        ss_we      = 1'b1;
                        ss_waddr   = count_reg[AW-1:0];
                        ss_wdata   = item.value[SW-1:0];
                        count_next = n_after;
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (item.last)
                    begin
                        rw_next     = RW'(2);
                        lo_next     = '0;
                        tm_vld_next = 1'b0;
                        emit_k_next = '0;
                    end
                end
            end
            ST_PASS_CHK:
            begin
                k_next = '0;
                if (full_run)
                begin
                    tail_next  = 1'b0;
                    m_lo_next  = AW'(lo_reg);
                    mid_next   = AW'(full_mid);
                    hi_next    = AW'(run_end - EW'(1));
                    l_ptr_next = lo_reg;
                    r_ptr_next = CW'(full_mid + EW'(1));
                end
                else if (tail_has)
                begin
                    // short tail merged against its sorted prefix
                    tm_vld_next = 1'b1;
                    tm_next     = tail_merge ? AW'(lo_reg - CW'(1)) : tm_eff;
                    tail_next   = 1'b1;
                    m_lo_next   = AW'(lo_reg);
                    mid_next    = tm_eff;
                    hi_next     = AW'(count_reg - CW'(1));
                    l_ptr_next  = lo_reg;
                    r_ptr_next  = CW'(tm_eff) + CW'(1);
                end
            end
            ST_PASS_END:
            begin
                emit_k_next = '0;
                if (rw_reg < RW'(count_reg))
                begin
                    rw_next = rw_reg << 1;
                    lo_next = '0;
                end
            end
            ST_MRG_RDL:
            begin
                ss_raddr = AW'(l_ptr_reg);
            end
            ST_MRG_RDR:
            begin
                ss_raddr    = AW'(r_ptr_reg);
                head_l_next = $signed(ss_rdata);
            end
            ST_MRG_GETR:
            begin
                head_r_next = $signed(ss_rdata);
            end
            ST_MRG_STEP:
            begin
                if (l_ok || r_ok)
                begin
                    buf_we      = 1'b1;
                    k_next      = k_reg + CW'(1);
                    take_r_next = take_r;
                    if (take_r)
                    begin
                        r_ptr_next = r_ptr_reg + CW'(1);
                        ss_raddr   = AW'(r_ptr_reg + CW'(1));
                    end
                    else
                    begin
                        l_ptr_next = l_ptr_reg + CW'(1);
                        ss_raddr   = AW'(l_ptr_reg + CW'(1));
                    end
                end
                else
                begin
                    cp_i_next = '0;
                end
            end
            ST_MRG_REFILL:
            begin
                if (take_r_reg)
                begin
                    head_r_next = $signed(ss_rdata);
                end
                else
                begin
                    head_l_next = $signed(ss_rdata);
                end
            end
            ST_MRG_COPY:
            begin
                // read buffer one ahead, write back to the run base
                ss_we = cp_wv_reg;
                if (cp_issue)
                begin
                    cp_i_next     = cp_i_reg + CW'(1);
                    cp_wv_next    = 1'b1;
                    cp_waddr_next = m_lo_reg + AW'(cp_i_reg);
                end
                else if (!cp_wv_reg)
                begin
                    lo_next = CW'(hi_reg) + CW'(1);
                end
            end
            ST_EMIT_RD:
            begin
                ss_raddr = emit_k_reg;
            end
            ST_EMIT_LD:
            begin
                out_next.sorted_value = IO_W'($signed(ss_rdata));
                out_next.final_res    = emit_final;
                out_next.overflow     = dropped_reg;
                out_valid_next        = 1'b1;
            end
            ST_EMIT_HOLD:
            begin
                if (result_ready)
                begin
                    out_valid_next = 1'b0;
                    if (emit_final)
                    begin
                        count_next   = '0;
                        dropped_next = 1'b0;
                        rw_next      = RW'(2);
                        tm_vld_next  = 1'b0;
                    end
                    else
                    begin
                        emit_k_next = emit_k_reg + AW'(1);
                    end
                end
            end
            default:
            begin
                item_ready = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            rw_reg        <= RW'(2);
            lo_reg        <= '0;
            tm_reg        <= '0;
            tm_vld_reg    <= 1'b0;
            tail_reg      <= 1'b0;
            m_lo_reg      <= '0;
            mid_reg       <= '0;
            hi_reg        <= '0;
            l_ptr_reg     <= '0;
            r_ptr_reg     <= '0;
            k_reg         <= '0;
            take_r_reg    <= 1'b0;
            cp_i_reg      <= '0;
            cp_wv_reg     <= 1'b0;
            cp_waddr_reg  <= '0;
            emit_k_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            rw_reg        <= rw_next;
            lo_reg        <= lo_next;
            tm_reg        <= tm_next;
            tm_vld_reg    <= tm_vld_next;
            tail_reg      <= tail_next;
            m_lo_reg      <= m_lo_next;
            mid_reg       <= mid_next;
            hi_reg        <= hi_next;
            l_ptr_reg     <= l_ptr_next;
            r_ptr_reg     <= r_ptr_next;
            k_reg         <= k_next;
            take_r_reg    <= take_r_next;
            cp_i_reg      <= cp_i_next;
            cp_wv_reg     <= cp_wv_next;
            cp_waddr_reg  <= cp_waddr_next;
            emit_k_reg    <= emit_k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        head_l_reg <= head_l_next;
        head_r_reg <= head_r_next;
        out_reg    <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // checks
    `ASSERT_ALWAYS(a_no_overlap, clk, rst_n, !(item_ready && result_valid), "load during emit")
    `ASSERT_NEXT(a_final_reload, clk, rst_n, result_valid && result_ready && result.final_res, item_ready, "no reload after final result")
    `ASSERT_IMPLIES(a_copy_state, clk, rst_n, cp_wv_reg, state_reg == ST_MRG_COPY, "copy-back write outside copy")
    `ASSERT_ALWAYS(a_count_range, clk, rst_n, count_reg <= CW'(MAX_LEN), "item count past depth")

endmodule

`default_nettype wire
